/* rtl/core/ucf_pkg.sv */
// shared types and constants for the utf-8 case-fold stream core
// used by ucf_front, ucf_queue, ucf_back and the top level; no dependencies
`default_nettype none

package ucf_pkg;

	typedef logic [20:0] ucf_cp_t;
	typedef logic [3:0][7:0] ucf_bytes_t;

	typedef struct packed {
		logic       pt;
		ucf_cp_t    cp;
		ucf_bytes_t bytes;
		logic [3:0] raw;
		logic [2:0] n;
		logic       last;
	} ucf_rec_t;

	localparam ucf_cp_t CP_MAX     = 21'h10FFFF;
	localparam ucf_cp_t CP_SURR_LO = 21'h00D800;
	localparam ucf_cp_t CP_SURR_HI = 21'h00DFFF;
	localparam ucf_cp_t CP_2B_MIN  = 21'h000080;
	localparam ucf_cp_t CP_3B_MIN  = 21'h000800;
	localparam ucf_cp_t CP_4B_MIN  = 21'h010000;

	localparam logic [2:0] LEN_2 = 3'd2;
	localparam logic [2:0] LEN_3 = 3'd3;
	localparam logic [2:0] LEN_4 = 3'd4;

endpackage

`default_nettype wire

/* rtl/core/ucf_front.sv */
// front part: classifies each byte, holds open sequences, builds one queue record
// depends on ucf_pkg
`default_nettype none

module ucf_front import ucf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     accept,
	input  wire logic [7:0] in_byte,
	input  wire logic     in_last,
	output ucf_rec_t      rec,
	output logic          push
);

	logic [2:0][7:0] held_q, nxt_held;
	logic [1:0] cnt_q, nxt_cnt;
	logic [2:0] len_q, nxt_len;

	logic       cont, seven_bit, is_lead, fresh, complete, bad;
	logic [2:0] lead_len;
	logic [7:0] asc, x;
	ucf_cp_t    cp;

	always_comb begin
		cont      = in_byte[7:6] == 2'b10;
		seven_bit = !in_byte[7];
		lead_len = 3'd0;
		if (in_byte[7:5] == 3'b110)
			lead_len = LEN_2;
		else if (in_byte[7:4] == 4'b1110)
			lead_len = LEN_3;
		else if (in_byte[7:3] == 5'b11110)
			lead_len = LEN_4;
		is_lead = lead_len != 3'd0;
		asc = (in_byte >= 8'h41 && in_byte <= 8'h5A) ? in_byte + 8'h20 : in_byte;
		fresh = cnt_q == 2'd0 || !cont;
		x = (fresh && seven_bit) ? asc : in_byte;

		unique case (len_q)
			LEN_2:   cp = {10'd0, held_q[0][4:0], in_byte[5:0]};
			LEN_3:   cp = {5'd0, held_q[0][3:0], held_q[1][5:0], in_byte[5:0]};
			default: cp = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], in_byte[5:0]};
		endcase
		bad = (len_q == LEN_2 && cp < CP_2B_MIN) || (len_q == LEN_3 && cp < CP_3B_MIN)
			|| (len_q == LEN_4 && cp < CP_4B_MIN) || cp > CP_MAX
			|| (cp >= CP_SURR_LO && cp <= CP_SURR_HI);
		complete = ({1'b0, cnt_q} + 3'd1) >= len_q;

		rec.cp       = cp;
		rec.last     = in_last;
		rec.bytes[0] = (cnt_q == 2'd0) ? x : held_q[0];
		rec.bytes[1] = (cnt_q <= 2'd1) ? x : held_q[1];
		rec.bytes[2] = (cnt_q <= 2'd2) ? x : held_q[2];
		rec.bytes[3] = x;
		rec.raw[0]   = (cnt_q > 2'd0) || !(fresh && seven_bit);
		rec.raw[1]   = (cnt_q > 2'd1) || !(fresh && seven_bit);
		rec.raw[2]   = (cnt_q > 2'd2) || !(fresh && seven_bit);
		rec.raw[3]   = !(fresh && seven_bit);
		rec.pt       = 1'b0;
		rec.n        = 3'd0;

		nxt_held = held_q;
		nxt_cnt  = cnt_q;
		nxt_len  = len_q;

		if (fresh) begin
			if (is_lead && !in_last) begin
				rec.n       = {1'b0, cnt_q};
				nxt_held[0] = in_byte;
				nxt_cnt     = 2'd1;
				nxt_len     = lead_len;
			end else begin
				rec.n   = {1'b0, cnt_q} + 3'd1;
				nxt_cnt = 2'd0;
				nxt_len = 3'd0;
			end
		end else if (complete) begin
			nxt_cnt = 2'd0;
			nxt_len = 3'd0;
			if (!bad) begin
				rec.pt = 1'b1;
				rec.n  = 3'd1;
			end else begin
				rec.n = {1'b0, cnt_q} + 3'd1;
			end
		end else if (in_last) begin
			rec.n   = {1'b0, cnt_q} + 3'd1;
			nxt_cnt = 2'd0;
			nxt_len = 3'd0;
		end else if (cnt_q != 2'd3) begin
			nxt_held[cnt_q] = in_byte;
			nxt_cnt         = cnt_q + 2'd1;
		end

		push = accept && rec.n != 3'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			len_q <= 3'd0;
		end else if (accept) begin
			cnt_q <= nxt_cnt;
			len_q <= nxt_len;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			held_q <= nxt_held;
	end

endmodule

`default_nettype wire

/* rtl/core/ucf_queue.sv */
// short record queue between the front and back parts
// depends on ucf_pkg
`default_nettype none

module ucf_queue import ucf_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire ucf_rec_t wr_rec,
	input  wire logic     pop,
	output ucf_rec_t      rd_rec,
	output logic          full,
	output logic          empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ucf_rec_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full   = cnt_q == CW'(DEPTH);
	assign empty  = cnt_q == '0;
	assign rd_rec = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wr_rec;
	end

endmodule

`default_nettype wire

/* rtl/core/ucf_back.sv */
// back part: folds decoded code points, re-encodes them and sends one byte a
// cycle unless out_stall; depends on ucf_pkg
`default_nettype none

module ucf_back import ucf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ucf_rec_t rd_rec,
	input  wire logic     empty,
	output logic          pop,
	output logic          out_valid,
	input  wire logic     out_stall,
	output logic [7:0]    out_byte,
	output logic          run_last,
	output logic          text_end,
	output logic          passed_raw
);

	function automatic ucf_cp_t fold(input ucf_cp_t cp);
		ucf_cp_t r;
		r = cp;
		if (cp < 21'h80) begin
			if (cp >= 21'h41 && cp <= 21'h5A)
				r = cp + 21'h20;
		end else if (cp >= 21'hC0 && cp <= 21'hDE && cp != 21'hD7) begin
			r = cp + 21'h20;
		end else if (cp >= 21'h100 && cp <= 21'h17F) begin
			if (cp == 21'h130)
				r = 21'h69;
			else if (cp == 21'h131 || cp == 21'h138 || cp == 21'h149)
				r = cp;
			else if (cp == 21'h178)
				r = 21'hFF;
			else if (cp == 21'h17F)
				r = 21'h73;
			else if ((cp >= 21'h139 && cp <= 21'h148) || (cp >= 21'h179 && cp <= 21'h17E))
				r = cp[0] ? cp + 21'd1 : cp;
			else
				r = cp[0] ? cp : cp + 21'd1;
		end else if (cp >= 21'h391 && cp <= 21'h3A9 && cp != 21'h3A2) begin
			r = cp + 21'h20;
		end else if (cp >= 21'h410 && cp <= 21'h42F) begin
			r = cp + 21'h20;
		end else if (cp >= 21'h400 && cp <= 21'h40F) begin
			r = cp + 21'h50;
		end
		return r;
	endfunction

	ucf_bytes_t bytes_q, ld_bytes;
	logic [3:0] raw_q, ld_raw;
	logic [2:0] n_q, ld_n;
	logic       last_q, valid_q, done, accept, load;
	logic [1:0] idx_q;
	ucf_cp_t    f;

	always_comb begin
		f        = fold(rd_rec.cp);
		ld_bytes = rd_rec.bytes;
		ld_raw   = rd_rec.raw;
		ld_n     = rd_rec.n;
		if (rd_rec.pt) begin
			ld_raw   = 4'b0000;
			ld_bytes = '0;
			if (f < CP_2B_MIN) begin
				ld_n        = 3'd1;
				ld_bytes[0] = f[7:0];
			end else if (f < CP_3B_MIN) begin
				ld_n        = 3'd2;
				ld_bytes[0] = {3'b110, f[10:6]};
				ld_bytes[1] = {2'b10, f[5:0]};
			end else if (f < CP_4B_MIN) begin
				ld_n        = 3'd3;
				ld_bytes[0] = {4'b1110, f[15:12]};
				ld_bytes[1] = {2'b10, f[11:6]};
				ld_bytes[2] = {2'b10, f[5:0]};
			end else begin
				ld_n        = 3'd4;
				ld_bytes[0] = {5'b11110, f[20:18]};
				ld_bytes[1] = {2'b10, f[17:12]};
				ld_bytes[2] = {2'b10, f[11:6]};
				ld_bytes[3] = {2'b10, f[5:0]};
			end
		end
	end

	assign out_valid  = valid_q;
	assign accept     = valid_q && !out_stall;
	assign done       = ({1'b0, idx_q} + 3'd1) == n_q;
	assign load       = !valid_q || (accept && done);
	assign pop        = load && !empty;
	assign out_byte   = bytes_q[idx_q];
	assign passed_raw = raw_q[idx_q];
	assign run_last   = done;
	assign text_end   = done && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= !empty;
			idx_q   <= 2'd0;
		end else if (accept) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bytes_q <= ld_bytes;
			raw_q   <= ld_raw;
			n_q     <= ld_n;
			last_q  <= rd_rec.last;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/utf8_casefold_stream_core.sv */
// utf-8 simple case-fold stream core: one byte in, one byte out per cycle unless stalled
// path: an accepted item goes through the record queue into the output stage register
// throughput: one input item per cycle while the record queue has room; the single output
// byte lane sends the up to four result bytes of an item one per cycle unless out_stall
// reset: arst_n clears the open sequence, the queue and the output stage at once
`default_nettype none

module utf8_casefold_stream_core import ucf_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            text_end,
	output logic            passed_raw
);

	ucf_rec_t wr_rec, rd_rec;
	logic     push, pop, full, empty;

	assign in_stall = full;

	ucf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_valid && !full),
		.in_byte (in_byte),
		.in_last (in_last),
		.rec     (wr_rec),
		.push    (push)
	);

	ucf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.pop    (pop),
		.rd_rec (rd_rec),
		.full   (full),
		.empty  (empty)
	);

	ucf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_rec     (rd_rec),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.text_end   (text_end),
		.passed_raw (passed_raw)
	);

endmodule

`default_nettype wire
